@@ hdl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg
// shared types and constants of the piecewise linear interpolator
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int TABLE_DEPTH       = 16;
   localparam int VALUE_WIDTH       = 16;
   localparam int ADDR_WIDTH        = $clog2(TABLE_DEPTH);
   localparam int ENTRY_INDEX_WIDTH = 4;
   localparam int COUNT_WIDTH       = 5;
   localparam int PROD_WIDTH        = 2 * VALUE_WIDTH;
   localparam int STEP_WIDTH        = $clog2(VALUE_WIDTH + 1);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] x;
      logic [VALUE_WIDTH-1:0] y;
   } entry_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_WIDTH-1:0] addr;
      entry_type             data;
   } ram_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK_LAST,
      ST_CHECK_FIRST,
      ST_SCAN,
      ST_MULT,
      ST_DIV_LOAD,
      ST_DIVIDE
   } state_type;

endpackage

@@ hdl/pli_table_ram.sv @@
// ----------------------------------------------------------------------------
// pli_table_ram
// breakpoint table, one write port and one registered read port
// ----------------------------------------------------------------------------
module pli_table_ram (
   input  logic                           clock,
   input  pli_pkg::ram_wr_type            wr,
   input  logic                           rd_en,
   input  logic [pli_pkg::ADDR_WIDTH-1:0] rd_addr,
   output pli_pkg::entry_type             rd_data
);

   pli_pkg::entry_type mem [pli_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hdl/pli_divider.sv @@
// ----------------------------------------------------------------------------
// pli_divider
// restoring divider, one quotient bit per cycle; the upper half of the
// dividend must be below the divisor
// ----------------------------------------------------------------------------
module pli_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pli_pkg::PROD_WIDTH-1:0]  dividend,
   input  logic [pli_pkg::VALUE_WIDTH-1:0] divisor,
   output logic                            done,
   output logic [pli_pkg::VALUE_WIDTH-1:0] quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [pli_pkg::STEP_WIDTH-1:0]  count_ff, count_in;
   logic [pli_pkg::VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [pli_pkg::VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [pli_pkg::VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic [pli_pkg::VALUE_WIDTH:0]   trial;
   logic                            fits;

   assign trial = {rem_ff, shift_ff[pli_pkg::VALUE_WIDTH-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = pli_pkg::STEP_WIDTH'(pli_pkg::VALUE_WIDTH);
         rem_in     = dividend[pli_pkg::PROD_WIDTH-1:pli_pkg::VALUE_WIDTH];
         shift_in   = dividend[pli_pkg::VALUE_WIDTH-1:0];
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? pli_pkg::VALUE_WIDTH'(trial - {1'b0, divisor_ff})
                         : trial[pli_pkg::VALUE_WIDTH-1:0];
         shift_in = {shift_ff[pli_pkg::VALUE_WIDTH-2:0], fits};
         count_in = count_ff - pli_pkg::STEP_WIDTH'(1);
         if (count_ff == pli_pkg::STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a finished division");

   a_step_count_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0 &&
                  count_ff <= pli_pkg::STEP_WIDTH'(pli_pkg::VALUE_WIDTH))
      else $error("step count out of range while busy");

endmodule

@@ hdl/piecewise_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// breakpoint table with linear interpolation between entries
// ----------------------------------------------------------------------------
// write word: busy stays low, next word taken the cycle after
// query: empty table: busy stays low, strobe follows; last y at or above
//   the last x, first y at or below the first x, else one table read per
//   scanned slot up to interval end i, then multiply and 16 divider steps
// busy falls as the strobe rises; the receiver takes every word as shown
// sync reset: idle, point_count 0, table contents undefined until written
module piecewise_linear_interpolator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_command,
   input  logic [pli_pkg::ENTRY_INDEX_WIDTH-1:0] req_entry_index,
   input  logic [pli_pkg::VALUE_WIDTH-1:0]       req_entry_x,
   input  logic [pli_pkg::VALUE_WIDTH-1:0]       req_entry_y,
   input  logic [pli_pkg::VALUE_WIDTH-1:0]       req_query_x,
   output logic                                  rsp_valid,
   output logic [pli_pkg::VALUE_WIDTH-1:0]       rsp_result_y,
   input  logic                                  csr_wr_en,
   input  logic [pli_pkg::COUNT_WIDTH-1:0]       csr_wr_data
);

   pli_pkg::state_type              state_ff, state_in;
   logic [pli_pkg::COUNT_WIDTH-1:0] point_count_ff, count_sat;
   logic [pli_pkg::COUNT_WIDTH-1:0] n_ff, n_in;
   logic [pli_pkg::ADDR_WIDTH-1:0]  idx_ff, idx_in, last_addr;
   logic [pli_pkg::VALUE_WIDTH-1:0] q_ff, q_in;
   pli_pkg::entry_type              prev_ff, prev_in, cur_ff, cur_in;
   logic [pli_pkg::PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic [pli_pkg::VALUE_WIDTH-1:0] dx_ff, dx_in;
   logic                            neg_ff, neg_in;
   logic                            rsp_valid_ff;
   logic [pli_pkg::VALUE_WIDTH-1:0] rsp_result_ff;

   pli_pkg::ram_wr_type             ram_wr;
   logic                            ram_rd_en;
   logic [pli_pkg::ADDR_WIDTH-1:0]  ram_rd_addr;
   pli_pkg::entry_type              ram_rd_data;

   logic                            div_start, div_done;
   logic [pli_pkg::VALUE_WIDTH-1:0] div_quotient;

   logic                            finish;
   logic [pli_pkg::VALUE_WIDTH-1:0] finish_y;
   logic                            scan_stop;
   logic [pli_pkg::VALUE_WIDTH-1:0] dq, dy;

   assign count_sat = (32'(point_count_ff) > pli_pkg::TABLE_DEPTH)
                    ? pli_pkg::COUNT_WIDTH'(pli_pkg::TABLE_DEPTH) : point_count_ff;
   assign last_addr = pli_pkg::ADDR_WIDTH'(n_ff - pli_pkg::COUNT_WIDTH'(1));
   assign scan_stop = (ram_rd_data.x >= q_ff) || (idx_ff == last_addr);
   assign dq        = q_ff - prev_ff.x;
   assign dy        = (cur_ff.y >= prev_ff.y) ? cur_ff.y - prev_ff.y : prev_ff.y - cur_ff.y;

   pli_table_ram u_table (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (start && req_command == pli_pkg::CMD_QUERY &&
                count_sat != '0) begin
               state_in = pli_pkg::ST_CHECK_LAST;
            end
         end
         pli_pkg::ST_CHECK_LAST: begin
            state_in = (q_ff >= ram_rd_data.x) ? pli_pkg::ST_IDLE : pli_pkg::ST_CHECK_FIRST;
         end
         pli_pkg::ST_CHECK_FIRST: begin
            state_in = (q_ff <= ram_rd_data.x) ? pli_pkg::ST_IDLE : pli_pkg::ST_SCAN;
         end
         pli_pkg::ST_SCAN: begin
            if (scan_stop) begin
               state_in = pli_pkg::ST_MULT;
            end
         end
         pli_pkg::ST_MULT: begin
            state_in = (cur_ff.x <= prev_ff.x) ? pli_pkg::ST_IDLE : pli_pkg::ST_DIV_LOAD;
         end
         pli_pkg::ST_DIV_LOAD: begin
            state_in = pli_pkg::ST_DIVIDE;
         end
         pli_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ram_wr      = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      div_start   = 1'b0;
      finish      = 1'b0;
      finish_y    = '0;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (start) begin
               if (req_command == pli_pkg::CMD_WRITE) begin
                  ram_wr.en     = 32'(req_entry_index) < pli_pkg::TABLE_DEPTH;
                  ram_wr.addr   = pli_pkg::ADDR_WIDTH'(req_entry_index);
                  ram_wr.data.x = req_entry_x;
                  ram_wr.data.y = req_entry_y;
               end else if (count_sat == '0) begin
                  finish = 1'b1;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = pli_pkg::ADDR_WIDTH'(count_sat - pli_pkg::COUNT_WIDTH'(1));
               end
            end
         end
         pli_pkg::ST_CHECK_LAST: begin
            if (q_ff >= ram_rd_data.x) begin
               finish   = 1'b1;
               finish_y = ram_rd_data.y;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
            end
         end
         pli_pkg::ST_CHECK_FIRST: begin
            if (q_ff <= ram_rd_data.x) begin
               finish   = 1'b1;
               finish_y = ram_rd_data.y;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pli_pkg::ADDR_WIDTH'(1);
            end
         end
         pli_pkg::ST_SCAN: begin
            if (!scan_stop) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + pli_pkg::ADDR_WIDTH'(1);
            end
         end
         pli_pkg::ST_MULT: begin
            if (cur_ff.x <= prev_ff.x) begin
               finish   = 1'b1;
               finish_y = prev_ff.y;
            end
         end
         pli_pkg::ST_DIV_LOAD: begin
            div_start = 1'b1;
         end
         pli_pkg::ST_DIVIDE: begin
            if (div_done) begin
               finish   = 1'b1;
               finish_y = neg_ff ? prev_ff.y - div_quotient : prev_ff.y + div_quotient;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      q_in    = q_ff;
      n_in    = n_ff;
      idx_in  = idx_ff;
      prev_in = prev_ff;
      cur_in  = cur_ff;
      prod_in = prod_ff;
      dx_in   = dx_ff;
      neg_in  = neg_ff;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (start) begin
               q_in = req_query_x;
               n_in = count_sat;
            end
         end
         pli_pkg::ST_CHECK_FIRST: begin
            prev_in = ram_rd_data;
            idx_in  = pli_pkg::ADDR_WIDTH'(1);
         end
         pli_pkg::ST_SCAN: begin
            if (scan_stop) begin
               cur_in = ram_rd_data;
            end else begin
               prev_in = ram_rd_data;
               idx_in  = idx_ff + pli_pkg::ADDR_WIDTH'(1);
            end
         end
         pli_pkg::ST_MULT: begin
            prod_in = pli_pkg::PROD_WIDTH'(dq) * pli_pkg::PROD_WIDTH'(dy);
            dx_in   = cur_ff.x - prev_ff.x;
            neg_in  = cur_ff.y < prev_ff.y;
         end
         default: begin
            neg_in = neg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pli_pkg::ST_IDLE;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= finish;
         if (csr_wr_en) begin
            point_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      n_ff    <= n_in;
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      dx_ff   <= dx_in;
      neg_ff  <= neg_in;
      if (finish) begin
         rsp_result_ff <= finish_y;
      end
   end

   assign busy         = state_ff != pli_pkg::ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_y = rsp_result_ff;

   a_interval_brackets_query: assert property (@(posedge clock) disable iff (reset)
      state_ff == pli_pkg::ST_MULT |-> prev_ff.x < q_ff && cur_ff.x >= q_ff)
      else $error("interval does not bracket the query");

   a_scan_within_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == pli_pkg::ST_SCAN |-> idx_ff <= last_addr)
      else $error("scan ran past the last breakpoint");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == pli_pkg::ST_DIVIDE)
      else $error("divider finished outside the divide state");

endmodule

@@ sim/interpolator_checker.sv @@
// ----------------------------------------------------------------------------
// interpolator_checker
// watches the request, result and csr ports of the interpolator, keeps its
// own breakpoint table and count, predicts the y of every accepted query and
// compares each result word in order against the oldest prediction
// ----------------------------------------------------------------------------
module interpolator_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_command,
   input  logic [pli_pkg::ENTRY_INDEX_WIDTH-1:0] req_entry_index,
   input  logic [pli_pkg::VALUE_WIDTH-1:0]       req_entry_x,
   input  logic [pli_pkg::VALUE_WIDTH-1:0]       req_entry_y,
   input  logic [pli_pkg::VALUE_WIDTH-1:0]       req_query_x,
   input  logic                                  rsp_valid,
   input  logic [pli_pkg::VALUE_WIDTH-1:0]       rsp_result_y,
   input  logic                                  csr_wr_en,
   input  logic [pli_pkg::COUNT_WIDTH-1:0]       csr_wr_data,
   output int                                    mismatches,
   output int                                    pending
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [pli_pkg::VALUE_WIDTH-1:0] knot_x [pli_pkg::TABLE_DEPTH];
   logic [pli_pkg::VALUE_WIDTH-1:0] knot_y [pli_pkg::TABLE_DEPTH];
   logic [pli_pkg::COUNT_WIDTH-1:0] points_in_use;
   logic [pli_pkg::VALUE_WIDTH-1:0] expected_y [$];
   int                              fail_count = 0;

   function automatic logic [pli_pkg::VALUE_WIDTH-1:0] interpolated_y(
      input logic [pli_pkg::VALUE_WIDTH-1:0] q);
      int                              n;
      int                              i;
      logic [pli_pkg::ADDR_WIDTH-1:0]  last;
      logic [pli_pkg::ADDR_WIDTH-1:0]  hi;
      logic [pli_pkg::ADDR_WIDTH-1:0]  lo;
      logic [pli_pkg::PROD_WIDTH-1:0]  dx;
      logic [pli_pkg::PROD_WIDTH-1:0]  dq;
      logic [pli_pkg::PROD_WIDTH-1:0]  dy;
      logic [pli_pkg::PROD_WIDTH-1:0]  quo;
      logic [pli_pkg::VALUE_WIDTH-1:0] x1;
      logic [pli_pkg::VALUE_WIDTH-1:0] y1;
      logic [pli_pkg::VALUE_WIDTH-1:0] y2;
      n = int'(points_in_use);
      if (n > pli_pkg::TABLE_DEPTH) n = pli_pkg::TABLE_DEPTH;
      if (n == 0) return '0;
      last = pli_pkg::ADDR_WIDTH'(n - 1);
      if (q >= knot_x[last]) return knot_y[last];
      if (q <= knot_x[0]) return knot_y[0];
      i = 1;
      while (i < n - 1 && knot_x[pli_pkg::ADDR_WIDTH'(i)] < q) i++;
      hi = pli_pkg::ADDR_WIDTH'(i);
      lo = pli_pkg::ADDR_WIDTH'(i - 1);
      x1 = knot_x[lo];
      y1 = knot_y[lo];
      y2 = knot_y[hi];
      if (knot_x[hi] <= x1) return y1;
      dx = pli_pkg::PROD_WIDTH'(knot_x[hi] - x1);
      dq = pli_pkg::PROD_WIDTH'(q - x1);
      if (y2 >= y1) begin
         dy  = pli_pkg::PROD_WIDTH'(y2 - y1);
         quo = (dq * dy) / dx;
         return y1 + pli_pkg::VALUE_WIDTH'(quo);
      end
      dy  = pli_pkg::PROD_WIDTH'(y1 - y2);
      quo = (dq * dy) / dx;
      return y1 - pli_pkg::VALUE_WIDTH'(quo);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [pli_pkg::VALUE_WIDTH-1:0] want;
      if (reset) begin
         expected_y.delete();
         points_in_use = '0;
         for (int k = 0; k < pli_pkg::TABLE_DEPTH; k++) begin
            knot_x[k] = '0;
            knot_y[k] = '0;
         end
      end else begin
         if (rsp_valid) begin
            if (expected_y.size() == 0) begin
               report_mismatch($sformatf("unexpected result word y=%h", rsp_result_y));
            end else begin
               want = expected_y.pop_front();
               if (rsp_result_y !== want)
                  report_mismatch($sformatf("result_y got %h want %h", rsp_result_y, want));
            end
         end
         if (csr_wr_en) points_in_use = csr_wr_data;
         if (start && !busy) begin
            if (req_command == pli_pkg::CMD_WRITE) begin
               knot_x[req_entry_index] = req_entry_x;
               knot_y[req_entry_index] = req_entry_y;
            end else begin
               expected_y.push_back(interpolated_y(req_query_x));
            end
         end
      end
      pending    <= expected_y.size();
      mismatches <= fail_count;
   end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives the piecewise linear interpolator with table writes, queries and
// count changes: a directed pass over empty, clamped, interpolated and
// saturated-count cases, then random phases that mostly load ascending tables
// and query inside them, mixed with phases of random writes and queries.
// the sender works in random bursts; the checker beside the block predicts
// and compares, and this module gives the verdict
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   logic                                  clock           = 1'b0;
   logic                                  reset           = 1'b1;
   logic                                  start           = 1'b0;
   logic                                  busy;
   logic                                  req_command     = pli_pkg::CMD_WRITE;
   logic [pli_pkg::ENTRY_INDEX_WIDTH-1:0] req_entry_index = '0;
   logic [pli_pkg::VALUE_WIDTH-1:0]       req_entry_x     = '0;
   logic [pli_pkg::VALUE_WIDTH-1:0]       req_entry_y     = '0;
   logic [pli_pkg::VALUE_WIDTH-1:0]       req_query_x     = '0;
   logic                                  rsp_valid;
   logic [pli_pkg::VALUE_WIDTH-1:0]       rsp_result_y;
   logic                                  csr_wr_en       = 1'b0;
   logic [pli_pkg::COUNT_WIDTH-1:0]       csr_wr_data     = '0;
   int                                    mismatches;
   int                                    pending;

   int                                    words_sent = 0;
   int                                    burst_left = 0;
   int                                    active_count = 0;
   logic [pli_pkg::VALUE_WIDTH-1:0]       ladder_x [pli_pkg::TABLE_DEPTH];

   piecewise_linear_interpolator DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .rsp_valid       (rsp_valid),
      .rsp_result_y    (rsp_result_y),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   interpolator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .rsp_valid       (rsp_valid),
      .rsp_result_y    (rsp_result_y),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatches      (mismatches),
      .pending         (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[piecewise_linear_interpolator] ERROR");
      $finish;
   end

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      end
   endtask

   task automatic send_word(input logic cmd,
                            input logic [pli_pkg::ENTRY_INDEX_WIDTH-1:0] idx,
                            input logic [pli_pkg::VALUE_WIDTH-1:0] ex,
                            input logic [pli_pkg::VALUE_WIDTH-1:0] ey,
                            input logic [pli_pkg::VALUE_WIDTH-1:0] qx);
      req_command     <= cmd;
      req_entry_index <= idx;
      req_entry_x     <= ex;
      req_entry_y     <= ey;
      req_query_x     <= qx;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      if (cmd == pli_pkg::CMD_WRITE) ladder_x[idx] = ex;
      pace_sender();
   endtask

   task automatic write_entry(input int idx, input int ex, input int ey);
      send_word(pli_pkg::CMD_WRITE, pli_pkg::ENTRY_INDEX_WIDTH'(idx),
                pli_pkg::VALUE_WIDTH'(ex), pli_pkg::VALUE_WIDTH'(ey),
                pli_pkg::VALUE_WIDTH'($urandom));
   endtask

   task automatic query_at(input int qx);
      send_word(pli_pkg::CMD_QUERY, pli_pkg::ENTRY_INDEX_WIDTH'($urandom),
                pli_pkg::VALUE_WIDTH'($urandom), pli_pkg::VALUE_WIDTH'($urandom),
                pli_pkg::VALUE_WIDTH'(qx));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_point_count(input int value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= pli_pkg::COUNT_WIDTH'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_count = (value > pli_pkg::TABLE_DEPTH) ? pli_pkg::TABLE_DEPTH : value;
   endtask

   task automatic load_ascending_table();
      int x;
      int step_max;
      x = $urandom_range(0, 16'h2000);
      case ($urandom_range(0, 2))
         0:       step_max = 16'h0010;
         1:       step_max = 16'h0400;
         default: step_max = (16'hFFFF - x) / (pli_pkg::TABLE_DEPTH - 1);
      endcase
      for (int k = 0; k < pli_pkg::TABLE_DEPTH; k++) begin
         if (k > 0) x = x + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max));
         if (x > 16'hFFFF) x = 16'hFFFF;
         write_entry(k, x, $urandom_range(0, 16'hFFFF));
      end
   endtask

   task automatic query_inside_table(input int num);
      int lo;
      int hi;
      for (int k = 0; k < num; k++) begin
         if (active_count == 0) begin
            query_at($urandom_range(0, 16'hFFFF));
         end else begin
            lo = int'(ladder_x[0]);
            hi = int'(ladder_x[pli_pkg::ADDR_WIDTH'(active_count - 1)]);
            case ($urandom_range(0, 9))
               0:       query_at($urandom_range(0, 16'hFFFF));
               1:       query_at(int'(ladder_x[pli_pkg::ADDR_WIDTH'(
                                    $urandom_range(0, active_count - 1))]));
               2:       query_at(lo);
               3:       query_at(hi);
               default: query_at($urandom_range(lo, hi));
            endcase
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table after reset
      query_at(16'h0000);
      query_at(16'hFFFF);

      // ascending table with a duplicate x, falling, flat and rising spans
      write_entry(0, 16'h0000, 16'hFFFF);
      write_entry(1, 16'h1000, 16'h8000);
      write_entry(2, 16'h1000, 16'h2000);
      write_entry(3, 16'h2000, 16'h2000);
      write_entry(4, 16'h3000, 16'h9000);
      write_entry(5, 16'h4000, 16'h0000);
      write_entry(6, 16'h5000, 16'hFFFF);
      for (int k = 1; k <= 8; k++) write_entry(6 + k, 16'h5000 + k * 16'h1400, k * 16'h1F00);
      write_entry(15, 16'hFFFF, 16'h0000);

      set_point_count(pli_pkg::TABLE_DEPTH);
      query_at(16'h0000);
      query_at(16'hFFFF);
      query_at(16'h0800);
      query_at(16'h1000);
      query_at(16'h1800);
      query_at(16'h4800);
      query_at(16'hFFFE);

      // count above depth saturates, then counts of one and two
      set_point_count(17);
      query_at(16'h8000);
      set_point_count(31);
      query_at(16'hF800);
      set_point_count(1);
      query_at(16'h1234);
      set_point_count(2);
      query_at(16'h0C00);

      while (words_sent < 420) begin
         case ($urandom_range(0, 9))
            0:       set_point_count(0);
            1:       set_point_count(1);
            2:       set_point_count(2);
            3:       set_point_count(pli_pkg::TABLE_DEPTH);
            4:       set_point_count($urandom_range(17, 31));
            default: set_point_count($urandom_range(3, 15));
         endcase
         if ($urandom_range(0, 9) < 7) begin
            load_ascending_table();
            query_inside_table($urandom_range(12, 30));
         end else begin
            for (int k = 0; k < 20; k++) begin
               if ($urandom_range(0, 1) == 0)
                  write_entry($urandom_range(0, 15), $urandom_range(0, 16'hFFFF),
                              $urandom_range(0, 16'hFFFF));
               else
                  query_at($urandom_range(0, 16'hFFFF));
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("[piecewise_linear_interpolator] OK");
      else
         $display("[piecewise_linear_interpolator] ERROR");
      $finish;
   end

endmodule
